FILE: sv/pgd_pkg.sv
// Package for the polynomial regression gradient step block.
// Word types, codes, sequencer states and Q16.16 helpers; no dependencies.
package pgd_pkg;

   localparam int MAX_POINTS_DEF = 128;
   localparam int NUM_COEFFS_DEF = 4;

   localparam int CNT_W    = 11;   // holds a point count up to 2047
   localparam int LOSS_W   = 56;   // loss sum, 2^45 per point
   localparam int SSUM_W   = 44;   // signed error sum
   localparam int ACC_W    = 48;
   localparam int DIV_W    = 57;
   localparam int DCOUNT_W = 6;

   localparam logic [1:0] KIND_POINT  = 2'd0;
   localparam logic [1:0] KIND_COEFF  = 2'd1;
   localparam logic [1:0] KIND_STEP   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_RATE      = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_COUNT     = 2'd3;

   localparam logic [30:0] LOSS_MAX = 31'h7fff_ffff;

   typedef struct packed {
      logic [1:0]         kind;
      logic [6:0]         index;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic signed [31:0] coefficient_value;
   } pgd_req_type;

   typedef struct packed {
      logic [2:0]         coefficient_index;
      logic signed [31:0] new_coefficient;
      logic signed [31:0] gradient_value;
      logic [30:0]        mean_loss;
      logic signed [31:0] mean_error;
      logic               skipped;
      logic               last;
   } pgd_rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic [CNT_W-1:0]        divisor;
   } pgd_div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DIV_W-1:0] quotient;
   } pgd_div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD, ST_H_MUL, ST_H_ADD, ST_ERR, ST_L_MUL, ST_L_ACC,
      ST_G_MUL, ST_G_ACC, ST_P_MUL, ST_P_UPD, ST_DL_GO, ST_DL_WAIT,
      ST_DS_GO, ST_DS_WAIT, ST_DG_GO, ST_DG_WAIT, ST_LR_MUL, ST_UPD, ST_EMIT
   } pgd_state_type;

   function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic signed [31:0] qround(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + 64'sd32768) >>> 16;
      return sat32(t);
   endfunction

endpackage

FILE: sv/pgd_div.sv
// Restoring divider, one quotient bit per clock, truncating toward zero.
// Depends on pgd_pkg for the request and result word types.
module pgd_div (
   input  logic                     clock,
   input  logic                     reset,
   input  pgd_pkg::pgd_div_req_type div_req,
   output pgd_pkg::pgd_div_rsp_type div_rsp
);
   import pgd_pkg::*;

   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    dsr_ff, dsr_in;
   logic [DCOUNT_W-1:0] count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                neg_ff, neg_in;
   logic                done_ff, done_in;
   logic [CNT_W:0]      trial;
   logic                take;

   always_comb begin
      trial    = {rem_ff, quo_ff[DIV_W-1]};
      take     = trial >= {1'b0, dsr_ff};
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         neg_in   = div_req.dividend[DIV_W-1];
         quo_in   = div_req.dividend[DIV_W-1] ? DIV_W'(-div_req.dividend)
                                              : DIV_W'(div_req.dividend);
         rem_in   = '0;
         dsr_in   = div_req.divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = take ? CNT_W'(trial - {1'b0, dsr_ff}) : trial[CNT_W-1:0];
         quo_in   = {quo_ff[DIV_W-2:0], take};
         count_in = count_ff + 1'b1;
         if (count_ff == DCOUNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      count_ff <= count_in;
      neg_ff   <= neg_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

FILE: sv/polynomial_regression_gradient_step.sv
// One full-batch gradient descent step of polynomial regression over stored points.
// Depends on pgd_pkg and pgd_div.
//
// Load words are taken while idle. A step word is worked by one shared 33x33
// multiplier under a sequencer: for each point Horner, loss, then one multiply for
// each gradient term and each power, followed by divisions (start, quotient bits,
// hand-over) for the mean loss and the mean error, then for each gradient a
// division, a rate multiply, an update and the result word. A skipped step answers
// without walking the points. No new word is taken until the last result of a step
// has gone.
module polynomial_regression_gradient_step #(
   parameter int MAX_POINTS = pgd_pkg::MAX_POINTS_DEF,
   parameter int NUM_COEFFS = pgd_pkg::NUM_COEFFS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pgd_pkg::pgd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pgd_pkg::pgd_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import pgd_pkg::*;

   localparam int PTS_W = $clog2(MAX_POINTS);
   localparam int N_W   = $clog2(MAX_POINTS + 1);
   localparam int CI_W  = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;

   pgd_state_type state_ff, state_in;

   logic              enable_ff;
   logic [15:0]       rate_ff;
   logic [30:0]       thresh_ff;
   logic [7:0]        count_ff;
   logic [30:0]       prev_loss_ff, prev_loss_in;

   logic signed [31:0] coef_ff [NUM_COEFFS];
   logic signed [ACC_W-1:0] acc_ff [NUM_COEFFS];
   logic [63:0]        point_mem [MAX_POINTS];
   logic [63:0]        rd_ff;

   logic [PTS_W-1:0]   point_ff, point_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [CI_W-1:0]    j_ff, j_in;
   logic signed [31:0] p_ff, p_in, err_ff, err_in, pw_ff, pw_in, g_ff, g_in;
   logic signed [63:0] mul_ff, mul_in;
   logic [LOSS_W-1:0]  lsum_ff, lsum_in;
   logic signed [SSUM_W-1:0] ssum_ff, ssum_in;
   logic [30:0]        mloss_ff, mloss_in;
   logic signed [31:0] msigned_ff, msigned_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pgd_rsp_type        rsp_ff, rsp_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic signed [31:0] x_rd, y_rd, c_new;
   logic signed [63:0] dstep;
   logic [CI_W-1:0]    gidx;
   logic               req_take, step_skip, coef_wr, acc_wr, acc_clr;
   logic signed [ACC_W-1:0] acc_val;
   logic [N_W-1:0]     n_clamp;
   pgd_div_req_type    div_req;
   pgd_div_rsp_type    div_rsp;

   pgd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign req_take  = req_valid && !req_stall;
   assign step_skip = !enable_ff || (prev_loss_ff < thresh_ff);
   assign x_rd      = rd_ff[63:32];
   assign y_rd      = rd_ff[31:0];
   assign gidx      = CI_W'(NUM_COEFFS - 1) - j_ff;
   assign n_clamp   = (count_ff == 8'd0) ? N_W'(1) :
                      ({24'd0, count_ff} > 32'(MAX_POINTS)) ? N_W'(MAX_POINTS) :
                      N_W'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_data.kind == KIND_STEP) begin
               state_in = step_skip ? ST_EMIT : ST_RD;
            end
         end
         ST_RD:    state_in = (NUM_COEFFS > 1) ? ST_H_MUL : ST_ERR;
         ST_H_MUL: state_in = ST_H_ADD;
         ST_H_ADD: state_in = (j_ff == CI_W'(NUM_COEFFS - 1)) ? ST_ERR : ST_H_MUL;
         ST_ERR:   state_in = ST_L_MUL;
         ST_L_MUL: state_in = ST_L_ACC;
         ST_L_ACC: state_in = ST_G_MUL;
         ST_G_MUL: state_in = ST_G_ACC;
         ST_G_ACC: begin
            if (j_ff != CI_W'(NUM_COEFFS - 1)) begin
               state_in = ST_P_MUL;
            end else if (N_W'(point_ff) + 1'b1 == n_ff) begin
               state_in = ST_DL_GO;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_P_MUL:   state_in = ST_P_UPD;
         ST_P_UPD:   state_in = ST_G_MUL;
         ST_DL_GO:   state_in = ST_DL_WAIT;
         ST_DL_WAIT: state_in = div_rsp.done ? ST_DS_GO : ST_DL_WAIT;
         ST_DS_GO:   state_in = ST_DS_WAIT;
         ST_DS_WAIT: state_in = div_rsp.done ? ST_DG_GO : ST_DS_WAIT;
         ST_DG_GO:   state_in = ST_DG_WAIT;
         ST_DG_WAIT: state_in = div_rsp.done ? ST_LR_MUL : ST_DG_WAIT;
         ST_LR_MUL:  state_in = ST_UPD;
         ST_UPD:     state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = rsp_ff.last ? ST_IDLE : ST_DG_GO;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      mul_a = {p_ff[31], p_ff};
      mul_b = {x_rd[31], x_rd};
      case (state_ff)
         ST_L_MUL: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {err_ff[31], err_ff};
         end
         ST_G_MUL: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {pw_ff[31], pw_ff};
         end
         ST_P_MUL: mul_a = {pw_ff[31], pw_ff};
         ST_LR_MUL: begin
            mul_a = $signed({17'd0, rate_ff});
            mul_b = {g_ff[31], g_ff};
         end
         default: ;
      endcase
      mul_full = mul_a * mul_b;
      mul_in   = mul_full[63:0];

      point_in     = point_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      p_in         = p_ff;
      err_in       = err_ff;
      pw_in        = pw_ff;
      g_in         = g_ff;
      lsum_in      = lsum_ff;
      ssum_in      = ssum_ff;
      mloss_in     = mloss_ff;
      msigned_in   = msigned_ff;
      prev_loss_in = prev_loss_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      coef_wr      = 1'b0;
      acc_wr       = 1'b0;
      acc_clr      = 1'b0;
      acc_val      = acc_ff[gidx];
      dstep        = (mul_ff + 64'sd32768) >>> 16;
      c_new        = sat32(sx64(coef_ff[j_ff]) - dstep);
      div_req.start    = 1'b0;
      div_req.divisor  = CNT_W'(n_ff);
      div_req.dividend = {{(DIV_W-ACC_W){acc_ff[j_ff][ACC_W-1]}}, acc_ff[j_ff]};

      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_data.kind == KIND_STEP) begin
               if (step_skip) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.mean_loss = prev_loss_ff;
                  rsp_in.skipped   = 1'b1;
                  rsp_in.last      = 1'b1;
               end else begin
                  point_in = '0;
                  n_in     = n_clamp;
                  lsum_in  = '0;
                  ssum_in  = '0;
                  acc_clr  = 1'b1;
               end
            end
         end
         ST_RD: begin
            p_in = coef_ff[0];
            j_in = CI_W'(1);
         end
         ST_H_ADD: begin
            p_in = sat32(sx64(qround(mul_ff)) + sx64(coef_ff[j_ff]));
            j_in = j_ff + 1'b1;
         end
         ST_ERR: begin
            err_in = sat32(sx64(p_ff) - sx64(y_rd));
            pw_in  = 32'sd65536;
            j_in   = '0;
         end
         ST_L_ACC: begin
            lsum_in = lsum_ff + LOSS_W'(mul_ff[63:17]);
            ssum_in = ssum_ff + {{(SSUM_W-32){err_ff[31]}}, err_ff};
         end
         ST_G_ACC: begin
            acc_wr  = 1'b1;
            acc_val = acc_ff[gidx] + ACC_W'(qround(mul_ff));
            if (j_ff == CI_W'(NUM_COEFFS - 1)) begin
               point_in = point_ff + 1'b1;
            end
         end
         ST_P_UPD: begin
            pw_in = qround(mul_ff);
            j_in  = j_ff + 1'b1;
         end
         ST_DL_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = $signed({1'b0, lsum_ff});
         end
         ST_DL_WAIT: begin
            if (div_rsp.done) begin
               mloss_in = (div_rsp.quotient > $signed({26'd0, LOSS_MAX})) ? LOSS_MAX
                          : div_rsp.quotient[30:0];
            end
         end
         ST_DS_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {{(DIV_W-SSUM_W){ssum_ff[SSUM_W-1]}}, ssum_ff};
            prev_loss_in     = mloss_ff;
         end
         ST_DS_WAIT: begin
            if (div_rsp.done) begin
               msigned_in = sat32({{(64-DIV_W){div_rsp.quotient[DIV_W-1]}},
                                   div_rsp.quotient});
               j_in = '0;
            end
         end
         ST_DG_GO: div_req.start = 1'b1;
         ST_DG_WAIT: begin
            if (div_rsp.done) begin
               g_in = sat32({{(64-DIV_W){div_rsp.quotient[DIV_W-1]}}, div_rsp.quotient});
            end
         end
         ST_UPD: begin
            coef_wr      = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in.coefficient_index = 3'(j_ff);
            rsp_in.new_coefficient   = c_new;
            rsp_in.gradient_value    = g_ff;
            rsp_in.mean_loss         = mloss_ff;
            rsp_in.mean_error        = msigned_ff;
            rsp_in.skipped           = 1'b0;
            rsp_in.last              = (j_ff == CI_W'(NUM_COEFFS - 1));
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               j_in         = j_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b1;
         rate_ff      <= 16'd655;
         thresh_ff    <= 31'd1;
         count_ff     <= 8'd100;
         prev_loss_ff <= LOSS_MAX;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_COEFFS; k++) begin
            coef_ff[k] <= '0;
            acc_ff[k]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         prev_loss_ff <= prev_loss_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:    enable_ff <= csr_data[0];
               CSR_RATE:      rate_ff   <= csr_data[15:0];
               CSR_THRESHOLD: thresh_ff <= csr_data[30:0];
               CSR_COUNT:     count_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
         if (req_take && req_data.kind == KIND_COEFF &&
             {25'd0, req_data.index} < 32'(NUM_COEFFS)) begin
            coef_ff[CI_W'(req_data.index)] <= req_data.coefficient_value;
         end else if (coef_wr) begin
            coef_ff[j_ff] <= c_new;
         end
         if (acc_clr) begin
            for (int k = 0; k < NUM_COEFFS; k++) begin
               acc_ff[k] <= '0;
            end
         end else if (acc_wr) begin
            acc_ff[gidx] <= acc_val;
         end
      end
      point_ff   <= point_in;
      n_ff       <= n_in;
      j_ff       <= j_in;
      p_ff       <= p_in;
      err_ff     <= err_in;
      pw_ff      <= pw_in;
      g_ff       <= g_in;
      mul_ff     <= mul_in;
      lsum_ff    <= lsum_in;
      ssum_ff    <= ssum_in;
      mloss_ff   <= mloss_in;
      msigned_ff <= msigned_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (req_take && req_data.kind == KIND_POINT &&
          {25'd0, req_data.index} < 32'(MAX_POINTS)) begin
         point_mem[PTS_W'(req_data.index)] <= {req_data.x_value, req_data.y_value};
      end
      rd_ff <= point_mem[point_ff];
   end

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rsp_valid_ff)
      else $error("result word shown while idle");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && rsp_ff.last |=> state_ff == ST_IDLE)
      else $error("step did not finish after its last word");

   a_point_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> N_W'(point_ff) < n_ff)
      else $error("point walk ran past the count");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DL_WAIT || state_ff == ST_DS_WAIT ||
                        state_ff == ST_DG_WAIT))
      else $error("division finished outside a wait state");

endmodule

FILE: bench/polynomial_regression_gradient_step_tb.sv
// Testbench for polynomial_regression_gradient_step: directed and random load and
// step words checked against an in-bench Q16.16 gradient descent predictor.
// Depends on pgd_pkg and the block under test only.
module polynomial_regression_gradient_step_tb;
   import pgd_pkg::*;

   localparam int  NPTS  = 128;
   localparam int  NCOEF = 4;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam int  CYCLE_LIMIT = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pgd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pgd_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_ENABLE;
   logic [31:0] csr_data = '0;

   polynomial_regression_gradient_step DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic         fit_enable;
   logic [15:0]  fit_rate;
   logic [30:0]  fit_threshold;
   logic [7:0]   fit_count;
   longint       px [NPTS];
   longint       py [NPTS];
   longint       coef [NCOEF];
   longint       last_loss;
   pgd_rsp_type  pending_results[$];

   int  errors = 0;
   int  cycles = 0;
   int  words_sent = 0;
   int  steps_run = 0;
   int  steps_skipped = 0;
   int  hold_cycles = 0;
   bit  quiet = 0;

   function automatic longint clip32(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   function automatic longint qmul16(longint a, longint b);
      return clip32((a * b + 64'sd32768) >>> 16);
   endfunction

   task automatic apply_word(pgd_req_type w);
      longint n, sum_sig, x, p, e, mloss, msig, g, d;
      longint gacc [NCOEF];
      longint pw [NCOEF];
      longint unsigned sum_loss;
      pgd_rsp_type r;
      if (w.kind == KIND_POINT) begin
         px[w.index] = w.x_value;
         py[w.index] = w.y_value;
      end else if (w.kind == KIND_COEFF) begin
         if (w.index < NCOEF) coef[w.index] = w.coefficient_value;
      end else if (w.kind == KIND_STEP) begin
         r = '0;
         if (!fit_enable || last_loss < fit_threshold) begin
            r.mean_loss = last_loss[30:0];
            r.skipped = 1'b1;
            r.last = 1'b1;
            pending_results = {pending_results, r};
            steps_skipped++;
         end else begin
            n = fit_count;
            if (n < 1) n = 1;
            if (n > NPTS) n = NPTS;
            sum_loss = 0;
            sum_sig = 0;
            for (int j = 0; j < NCOEF; j++) gacc[j] = 0;
            for (int i = 0; i < n; i++) begin
               x = px[i];
               p = coef[0];
               for (int j = 1; j < NCOEF; j++) p = clip32(qmul16(p, x) + coef[j]);
               e = clip32(p - py[i]);
               sum_loss += longint'(unsigned'(e * e)) >> 17;
               sum_sig += e;
               pw[0] = 65536;
               for (int j = 1; j < NCOEF; j++) pw[j] = qmul16(pw[j-1], x);
               for (int j = 0; j < NCOEF; j++) gacc[j] += qmul16(e, pw[NCOEF-1-j]);
            end
            mloss = sum_loss / n;
            if (mloss > QMAX) mloss = QMAX;
            msig = clip32(sum_sig / n);
            last_loss = mloss;
            for (int j = 0; j < NCOEF; j++) begin
               g = clip32(gacc[j] / n);
               d = (longint'(fit_rate) * g + 64'sd32768) >>> 16;
               coef[j] = clip32(coef[j] - d);
               r.coefficient_index = 3'(j);
               r.new_coefficient = coef[j][31:0];
               r.gradient_value = g[31:0];
               r.mean_loss = mloss[30:0];
               r.mean_error = msig[31:0];
               r.skipped = 1'b0;
               r.last = (j == NCOEF - 1);
               pending_results = {pending_results, r};
            end
            steps_run++;
         end
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
   endtask

   task automatic check_result(pgd_rsp_type got);
      pgd_rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected result word", 1, 0);
         return;
      end
      want = pending_results.pop_front();
      if (got.coefficient_index !== want.coefficient_index)
         report_mismatch("coefficient_index", got.coefficient_index, want.coefficient_index);
      if (got.new_coefficient !== want.new_coefficient)
         report_mismatch("new_coefficient", got.new_coefficient, want.new_coefficient);
      if (got.gradient_value !== want.gradient_value)
         report_mismatch("gradient_value", got.gradient_value, want.gradient_value);
      if (got.mean_loss !== want.mean_loss)
         report_mismatch("mean_loss", got.mean_loss, want.mean_loss);
      if (got.mean_error !== want.mean_error)
         report_mismatch("mean_error", got.mean_error, want.mean_error);
      if (got.skipped !== want.skipped)
         report_mismatch("skipped", got.skipped, want.skipped);
      if (got.last !== want.last)
         report_mismatch("last", got.last, want.last);
   endtask

   // monitor: predict on accepted words, check accepted results
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:    fit_enable = csr_data[0];
               CSR_RATE:      fit_rate = csr_data[15:0];
               CSR_THRESHOLD: fit_threshold = csr_data[30:0];
               CSR_COUNT:     fit_count = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) apply_word(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 30);
      end
   end

   function automatic int gap_len();
      int k;
      if (quiet) return 0;
      k = $urandom_range(0, 99);
      if (k < 65) return 0;
      if (k < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(pgd_req_type w);
      int gap;
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      words_sent++;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      req_valid <= 1'b0;
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || req_stall) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_q(bit wide);
      if (wide || $urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 262143) - 131072;
   endfunction

   function automatic pgd_req_type point_word(int idx, logic [31:0] x, logic [31:0] y);
      pgd_req_type w;
      w = '0;
      w.kind = KIND_POINT;
      w.index = 7'(idx);
      w.x_value = x;
      w.y_value = y;
      w.coefficient_value = $urandom;
      return w;
   endfunction

   function automatic pgd_req_type coef_word(int idx, logic [31:0] c);
      pgd_req_type w;
      w = '0;
      w.kind = KIND_COEFF;
      w.index = 7'(idx);
      w.coefficient_value = c;
      w.x_value = $urandom;
      w.y_value = $urandom;
      return w;
   endfunction

   function automatic pgd_req_type step_word();
      pgd_req_type w;
      w.kind = KIND_STEP;
      w.index = 7'($urandom);
      w.x_value = $urandom;
      w.y_value = $urandom;
      w.coefficient_value = $urandom;
      return w;
   endfunction

   task automatic test_point_preload();
      for (int i = 0; i < NPTS; i++) send_word(point_word(i, rand_q(0), rand_q(0)));
   endtask

   task automatic test_directed();
      pgd_req_type w;
      write_csr(CSR_COUNT, 32'd2);
      write_csr(CSR_THRESHOLD, 32'd0);
      write_csr(CSR_RATE, 32'hffff);
      send_word(point_word(0, 32'h7fff_ffff, 32'h8000_0000));
      send_word(point_word(1, 32'h8000_0000, 32'h7fff_ffff));
      send_word(coef_word(0, 32'h7fff_ffff));
      send_word(coef_word(1, 32'h8000_0000));
      send_word(coef_word(2, 32'h0001_0000));
      send_word(coef_word(3, 32'hffff_ffff));
      send_word(coef_word(5, 32'h1234_5678));
      w = step_word();
      w.kind = KIND_UNUSED;
      send_word(w);
      send_word(step_word());
      send_word(point_word(0, 32'h0000_8000, 32'h0001_0000));
      send_word(point_word(1, 32'hffff_8000, 32'h0));
      send_word(step_word());
      wait_idle();
      write_csr(CSR_COUNT, 32'd0);
      write_csr(CSR_RATE, 32'd0);
      send_word(step_word());
      wait_idle();
      write_csr(CSR_COUNT, 32'hffff_ff80 | 32'd255);
      write_csr(CSR_RATE, 32'd655);
      send_word(step_word());
      wait_idle();
      write_csr(CSR_ENABLE, 32'd0);
      send_word(step_word());
      wait_idle();
      write_csr(CSR_ENABLE, 32'hffff_fffe | 32'd1);
      write_csr(CSR_THRESHOLD, 32'h7fff_ffff);
      send_word(step_word());
      wait_idle();
   endtask

   task automatic test_random_phases();
      int k, len;
      pgd_req_type w;
      while (words_sent < 230) begin
         quiet = ($urandom_range(0, 4) == 0);
         k = $urandom_range(0, 9);
         write_csr(CSR_ENABLE, (k == 0) ? 32'd0 : 32'd1);
         k = $urandom_range(0, 9);
         write_csr(CSR_RATE, (k == 0) ? 32'hffff : (k == 1) ? 32'd0 : $urandom);
         k = $urandom_range(0, 9);
         write_csr(CSR_THRESHOLD, (k < 5) ? 32'd0 : (k < 8) ? $urandom_range(0, 4096)
                   : $urandom);
         k = $urandom_range(0, 19);
         write_csr(CSR_COUNT, (k == 0) ? 32'd128 : (k == 1) ? 32'd0 : $urandom_range(1, 12));
         len = $urandom_range(8, 20);
         for (int i = 0; i < len; i++) begin
            k = $urandom_range(0, 99);
            if (k < 35) send_word(point_word($urandom_range(0, 127), rand_q(0), rand_q(0)));
            else if (k < 60) send_word(coef_word($urandom_range(0, 7), rand_q(0)));
            else if (k < 95) send_word(step_word());
            else begin
               w = step_word();
               w.kind = KIND_UNUSED;
               send_word(w);
            end
         end
         wait_idle();
      end
      quiet = 0;
   endtask

   task automatic test_result_backpressure();
      write_csr(CSR_ENABLE, 32'd1);
      write_csr(CSR_THRESHOLD, 32'd0);
      write_csr(CSR_COUNT, 32'd3);
      @(posedge clock);
      hold_cycles <= 600;
      for (int i = 0; i < 6; i++) begin
         send_word(coef_word(i % NCOEF, rand_q(0)));
         send_word(step_word());
      end
      wait_idle();
   endtask

   initial begin
      fit_enable = 1'b1;
      fit_rate = 16'd655;
      fit_threshold = 31'd1;
      fit_count = 8'd100;
      for (int i = 0; i < NPTS; i++) begin
         px[i] = 0;
         py[i] = 0;
      end
      for (int j = 0; j < NCOEF; j++) coef[j] = 0;
      last_loss = QMAX;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_point_preload();
      test_directed();
      test_result_backpressure();
      test_random_phases();
      wait_idle();
      repeat (100) @(posedge clock);
      $display("covered %0d words: %0d steps run, %0d skipped", words_sent, steps_run,
               steps_skipped);
      $display("%0d mismatches, %0d results still awaited", errors, pending_results.size());
      if (errors == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: polynomial_regression_gradient_step.f
sv/pgd_pkg.sv
sv/pgd_div.sv
sv/polynomial_regression_gradient_step.sv
bench/polynomial_regression_gradient_step_tb.sv
